[design/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg
// Shared sizes, types and helpers of the point-in-polygon test unit.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int MAX_VERTS   = 64;
    localparam int COORD_WIDTH = 16;

    localparam int IDX_W   = $clog2(MAX_VERTS);
    localparam int CNT_W   = $clog2(MAX_VERTS + 1);
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int FIELD_CNT_W = 7;

    localparam int S_TDATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    // x in the low half of a stored word
    typedef struct packed {
        t_coord y;
        t_coord x;
    } t_vertex;

    typedef struct packed {
        logic vld;
        logic last;
    } t_edge_tag;

    typedef struct packed {
        logic vld;
        logic last;
        logic hit;
    } t_edge_res;

    typedef struct packed {
        logic                   dropped;
        logic [FIELD_CNT_W-1:0] vertex_count;
        logic [FIELD_CNT_W-1:0] crossings;
        logic                   inside_res;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

    function automatic logic signed [DIFF_W-1:0] sx(input t_coord v);
        return {v[COORD_WIDTH-1], v};
    endfunction

    // count reported modulo the field width
    function automatic logic [FIELD_CNT_W-1:0] fit_cnt(input logic [CNT_W-1:0] v);
        logic [CNT_W+FIELD_CNT_W-1:0] e;
        e = {{FIELD_CNT_W{1'b0}}, v};
        return e[FIELD_CNT_W-1:0];
    endfunction

endpackage

[design/pip_ram.sv]
// ----------------------------------------------------------------------------
// pip_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/pip_edge.sv]
// ----------------------------------------------------------------------------
// pip_edge
// Three-stage edge test: does the rightward ray from the point cross the edge
// from p1 to p2? Exact signed cross-multiplication, no division.
// ----------------------------------------------------------------------------
module pip_edge
    import pip_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_edge_tag i_tag,
    input  t_coord    i_px,
    input  t_coord    i_py,
    input  t_vertex   i_p1,
    input  t_vertex   i_p2,
    output t_edge_res o_res
);

    // stage 1: differences and span check
    t_edge_tag                 r_tag1;
    logic                      r_ok1;
    logic                      r_up1;
    logic signed [DIFF_W-1:0]  r_a1;
    logic signed [DIFF_W-1:0]  r_b1;
    logic signed [DIFF_W-1:0]  r_a2;
    logic signed [DIFF_W-1:0]  r_b2;

    // stage 2: products
    t_edge_tag                 r_tag2;
    logic                      r_ok2;
    logic                      r_up2;
    logic signed [PROD_W-1:0]  r_pa;
    logic signed [PROD_W-1:0]  r_pb;

    // stage 3: decision
    t_edge_res                 r_res;

    logic   up;
    logic   in_span;
    t_coord lo;
    t_coord hi;

    always_comb begin
        up      = i_p2.y > i_p1.y;
        lo      = up ? i_p1.y : i_p2.y;
        hi      = up ? i_p2.y : i_p1.y;
        in_span = (i_py >= lo) && (i_py < hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1     <= '0;
            r_tag2     <= '0;
            r_res.vld  <= 1'b0;
            r_res.last <= 1'b0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_res.vld  <= r_tag2.vld;
            r_res.last <= r_tag2.last;
        end
        r_ok1 <= (i_p1.y != i_p2.y) && in_span;
        r_up1 <= up;
        r_a1  <= sx(i_py) - sx(i_p1.y);
        r_b1  <= sx(i_p2.x) - sx(i_p1.x);
        r_a2  <= sx(i_px) - sx(i_p1.x);
        r_b2  <= sx(i_p2.y) - sx(i_p1.y);

        r_ok2 <= r_ok1;
        r_up2 <= r_up1;
        r_pa  <= r_a1 * r_b1;
        r_pb  <= r_a2 * r_b2;

        r_res.hit <= r_ok2 && (r_up2 ? (r_pa > r_pb) : (r_pa < r_pb));
    end

    assign o_res = r_res;

endmodule

[design/point_in_polygon_test_unit.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit
// Ray-casting point-in-polygon test over a stored vertex table.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries op and restart, tdata
// the coordinates. An append (op 0) stores one vertex at the end of the table;
// restart empties the table first; an append to a full table is dropped and
// flagged. A query (op 1) casts a ray toward +x and counts crossed edges, the
// last vertex closing back to the first; odd parity means inside.
// Every request gives one result on the m_axis channel.
// An append's result is registered and valid in the cycle after acceptance.
// A query over n stored vertices reads the vertex RAM one entry per cycle
// (n + 1 walk steps including the closing edge), then passes the three
// stage edge test and the final count. An empty table skips the walk.
// One request is in work at a time; the next is taken once the block is idle
// and the output register is empty or being emptied.
// Reset clears the vertex count and the control state; table contents stay
// undefined and are never read before being written. A stalled receiver
// holds the result in the output register and blocks new requests.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit
    import pip_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // coord_x, coord_y
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // op, restart
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // inside_res, crossings, vertex_count, dropped
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [CNT_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_xc;
    t_coord               r_px;
    t_coord               r_py;
    t_vertex              r_first;
    t_vertex              r_prev;
    logic                 r_d_vld;
    logic                 r_d_first;
    logic                 r_d_wrap;
    logic                 r_out_vld;
    t_result              r_out;

    logic                 s_acc;
    logic                 out_free;
    logic                 in_op;
    logic                 in_restart;
    t_coord               in_x;
    t_coord               in_y;
    logic [CNT_W-1:0]     base;
    logic                 full;
    logic                 app_acc;
    logic                 qry_acc;

    logic                 ram_we;
    logic                 ram_re;
    logic                 step;
    logic                 step_wrap;
    t_vertex              wr_vtx;
    t_vertex              rd_vtx;
    t_vertex              cur;
    t_edge_tag            edge_tag;
    t_edge_res            edge_res;
    logic                 done_load;

    assign in_op      = i_s_axis_tuser[0];
    assign in_restart = i_s_axis_tuser[1];
    assign in_x       = i_s_axis_tdata[COORD_WIDTH-1:0];
    assign in_y       = i_s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign app_acc         = s_acc && (in_op == OP_APPEND);
    assign qry_acc         = s_acc && (in_op == OP_QUERY);

    assign base   = in_restart ? '0 : r_cnt;
    assign full   = base == CNT_W'(MAX_VERTS);
    assign wr_vtx = '{y: in_y, x: in_x};

    always_comb begin
        n_cnt = r_cnt;
        if (app_acc) begin
            n_cnt = full ? base : base + 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (qry_acc) begin
                    n_state = (r_cnt == '0) ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_idx == r_cnt) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (edge_res.vld && edge_res.last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        step      = 1'b0;
        step_wrap = 1'b0;
        done_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                ram_we = app_acc && !full;
            end
            ST_WALK: begin
                step      = 1'b1;
                step_wrap = r_idx == r_cnt;
                ram_re    = !step_wrap;
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                done_load = out_free;
            end
            default: begin
            end
        endcase
    end

    pip_ram #(
        .WIDTH ($bits(t_vertex)),
        .DEPTH (MAX_VERTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (base[IDX_W-1:0]),
        .i_wdata (wr_vtx),
        .i_re    (ram_re),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_vtx)
    );

    // closing edge takes the saved first vertex
    assign cur = r_d_wrap ? r_first : rd_vtx;

    always_comb begin
        edge_tag.vld  = r_d_vld && !(r_d_first && !r_d_wrap);
        edge_tag.last = r_d_wrap;
    end

    pip_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (edge_tag),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_p1    (r_prev),
        .i_p2    (cur),
        .o_res   (edge_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_d_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_d_vld <= step;
            if (qry_acc) begin
                r_idx <= '0;
            end else if (step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (app_acc || done_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end

        if (qry_acc) begin
            r_px <= in_x;
            r_py <= in_y;
        end
        r_d_first <= r_idx == '0;
        r_d_wrap  <= step_wrap;
        if (r_d_vld) begin
            r_prev <= cur;
            if (r_d_first && !r_d_wrap) begin
                r_first <= cur;
            end
        end

        if (qry_acc) begin
            r_xc <= '0;
        end else if (edge_res.vld && edge_res.hit) begin
            r_xc <= r_xc + 1'b1;
        end

        if (app_acc) begin
            r_out.dropped      <= full;
            r_out.vertex_count <= fit_cnt(n_cnt);
            r_out.crossings    <= '0;
            r_out.inside_res   <= 1'b0;
        end else if (done_load) begin
            r_out.dropped      <= 1'b0;
            r_out.vertex_count <= fit_cnt(r_cnt);
            r_out.crossings    <= fit_cnt(r_xc);
            r_out.inside_res   <= r_xc[0];
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

endmodule
